@@ src/ctm_pkg.sv @@
// Package for the cyclic tag machine: state, status and operation codes,
// register indexes, the production info type and small helper functions.
// No dependencies.
`default_nettype none

package ctm_pkg;

  // Operation carried by an input item.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } ctm_op_t;

  // Status reported with each result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } ctm_status_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_PROD0 = 3'd1;
  localparam logic [2:0] REG_PROD1 = 3'd2;
  localparam logic [2:0] REG_PROD2 = 3'd3;
  localparam logic [2:0] REG_PROD3 = 3'd4;

  localparam int unsigned PROD_W = 32;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned CNT_W  = 3;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_APPEND,
    S_FINISH
  } ctm_state_t;

  // Production selected by the marker, with its decoded length and the
  // effective production count.
  typedef struct packed {
    logic [PROD_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic [CNT_W-1:0]  count;
  } ctm_prod_t;

  // Length of a sentinel-encoded production: index of its highest one.
  function automatic logic [LEN_W-1:0] prod_length(input logic [PROD_W-1:0] v);
    logic [LEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (v[i]) begin
        len = LEN_W'(i);
      end
    end
    return len;
  endfunction

  // Production count as used: zero counts as one, above four as four.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    if (v == '0) begin
      c = CNT_W'(1);
    end else if (v > CNT_W'(4)) begin
      c = CNT_W'(4);
    end else begin
      c = v;
    end
    return c;
  endfunction

  // (marker + 1) modulo the count, for counts of one to four.
  function automatic logic [1:0] next_marker(input logic [1:0] m,
                                             input logic [CNT_W-1:0] c);
    logic [2:0] sum;
    logic [1:0] res;
    sum = {1'b0, m} + 3'd1;
    unique case (c)
      3'd1: res = 2'd0;
      3'd2: res = {1'b0, sum[0]};
      3'd3: res = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
      default: res = sum[1:0];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/ctm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module ctm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ src/ctm_cfg.sv @@
// Configuration registers: production count and the four productions, with
// lengths decoded at write time. Depends on ctm_pkg.
`default_nettype none

module ctm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [ctm_pkg::PROD_W-1:0]   cfg_wdata,
  input  wire logic [1:0]                   marker,
  output ctm_pkg::ctm_prod_t                prod
);

  logic [ctm_pkg::PROD_W-1:0] prod_r  [4];
  logic [ctm_pkg::LEN_W-1:0]  len_r   [4];
  logic [ctm_pkg::CNT_W-1:0]  count_r;

  // Register writes; each production's length is decoded as it is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= ctm_pkg::CNT_W'(1);
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= ctm_pkg::PROD_W'(1);
        len_r[i]  <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ctm_pkg::REG_COUNT: count_r <= ctm_pkg::eff_count(cfg_wdata[ctm_pkg::CNT_W-1:0]);
        ctm_pkg::REG_PROD0: begin
          prod_r[0] <= cfg_wdata;
          len_r[0]  <= ctm_pkg::prod_length(cfg_wdata);
        end
        ctm_pkg::REG_PROD1: begin
          prod_r[1] <= cfg_wdata;
          len_r[1]  <= ctm_pkg::prod_length(cfg_wdata);
        end
        ctm_pkg::REG_PROD2: begin
          prod_r[2] <= cfg_wdata;
          len_r[2]  <= ctm_pkg::prod_length(cfg_wdata);
        end
        ctm_pkg::REG_PROD3: begin
          prod_r[3] <= cfg_wdata;
          len_r[3]  <= ctm_pkg::prod_length(cfg_wdata);
        end
        default: ;
      endcase
    end
  end

  // Production selected by the marker.
  always_comb begin
    prod.bits  = prod_r[marker];
    prod.len   = len_r[marker];
    prod.count = count_r;
  end

endmodule

`default_nettype wire

@@ src/ctm_seq.sv @@
// Sequencer: tape pointers, occupancy, marker, the read-modify-append
// sequence on the tape memory and the output register. Depends on ctm_pkg.
`default_nettype none

module ctm_seq #(
  parameter int unsigned TAPE_DEPTH = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_operation,
  input  wire logic                            in_tape_bit,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_status,
  output logic                                 out_popped_bit,
  output logic [1:0]                           out_marker_now,
  output logic [8:0]                           out_tape_length,
  input  wire ctm_pkg::ctm_prod_t              prod,
  output logic [1:0]                           marker,
  output logic                                 mem_wr_en,
  output logic [$clog2(TAPE_DEPTH)-1:0]        mem_wr_addr,
  output logic                                 mem_wr_data,
  output logic [$clog2(TAPE_DEPTH)-1:0]        mem_rd_addr,
  input  wire logic                            mem_rd_data
);

  localparam int unsigned PTR_W = $clog2(TAPE_DEPTH);
  localparam int unsigned OCC_W = $clog2(TAPE_DEPTH + 1);
  localparam int unsigned SUM_W = OCC_W + 6;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(TAPE_DEPTH);

  ctm_pkg::ctm_state_t  state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [1:0]           marker_r, marker_nxt;
  logic [ctm_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  ctm_pkg::ctm_status_t status_r, status_nxt;
  logic                 popped_r, popped_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 out_popped_r, out_popped_nxt;
  logic [1:0]           out_marker_r, out_marker_nxt;
  logic [8:0]           out_len_r, out_len_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 no_room;
  logic [SUM_W-1:0]     need;
  logic [PTR_W-1:0]     tail_inc;
  logic [PTR_W-1:0]     head_inc;
  logic [OCC_W+8:0]     occ_ext;

  assign accept   = in_valid && (state_r == ctm_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  // Occupancy after the pop plus the production length, against the depth.
  assign need     = SUM_W'(occ_r) - SUM_W'(1) + SUM_W'(prod.len);
  assign no_room  = need > SUM_W'(TAPE_DEPTH);
  assign occ_ext  = {9'd0, occ_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctm_pkg::S_IDLE: begin
        if (accept) begin
          if (in_operation == ctm_pkg::OP_STEP && occ_r != '0) begin
            state_nxt = ctm_pkg::S_READ;
          end else begin
            state_nxt = ctm_pkg::S_FINISH;
          end
        end
      end
      ctm_pkg::S_READ: begin
        if (mem_rd_data && !no_room && prod.len != '0) begin
          state_nxt = ctm_pkg::S_APPEND;
        end else begin
          state_nxt = ctm_pkg::S_FINISH;
        end
      end
      ctm_pkg::S_APPEND: begin
        if (cnt_r == prod.len - ctm_pkg::LEN_W'(1)) begin
          state_nxt = ctm_pkg::S_FINISH;
        end
      end
      ctm_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = ctm_pkg::S_IDLE;
        end
      end
      default: state_nxt = ctm_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls per state.
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    marker_nxt     = marker_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    popped_nxt     = popped_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_popped_nxt = out_popped_r;
    out_marker_nxt = out_marker_r;
    out_len_nxt    = out_len_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = tail_r;
    mem_wr_data    = in_tape_bit;
    in_stall       = 1'b1;
    unique case (state_r)
      ctm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          status_nxt = ctm_pkg::ST_OK;
          popped_nxt = 1'b0;
          if (in_operation == ctm_pkg::OP_LOAD) begin
            if (occ_r == OCC_FULL) begin
              status_nxt = ctm_pkg::ST_FULL;
            end else begin
              mem_wr_en = 1'b1;
              tail_nxt  = tail_inc;
              occ_nxt   = occ_r + OCC_W'(1);
            end
          end else if (occ_r == '0) begin
            status_nxt = ctm_pkg::ST_EMPTY;
          end
        end
      end
      ctm_pkg::S_READ: begin
        // Head bit is on the memory output now: pop it.
        popped_nxt = mem_rd_data;
        head_nxt   = head_inc;
        occ_nxt    = occ_r - OCC_W'(1);
        cnt_nxt    = '0;
        if (mem_rd_data && no_room) begin
          status_nxt = ctm_pkg::ST_FULL;
        end else if (!mem_rd_data || prod.len == '0) begin
          marker_nxt = ctm_pkg::next_marker(marker_r, prod.count);
        end
      end
      ctm_pkg::S_APPEND: begin
        // One production bit per cycle into the tail.
        mem_wr_en   = 1'b1;
        mem_wr_data = prod.bits[cnt_r];
        tail_nxt    = tail_inc;
        occ_nxt     = occ_r + OCC_W'(1);
        cnt_nxt     = cnt_r + ctm_pkg::LEN_W'(1);
        if (cnt_r == prod.len - ctm_pkg::LEN_W'(1)) begin
          marker_nxt = ctm_pkg::next_marker(marker_r, prod.count);
        end
      end
      ctm_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_popped_nxt = popped_r;
          out_marker_nxt = marker_r;
          out_len_nxt    = occ_ext[8:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctm_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      marker_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      marker_r    <= marker_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    popped_r     <= popped_nxt;
    out_status_r <= out_status_nxt;
    out_popped_r <= out_popped_nxt;
    out_marker_r <= out_marker_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign mem_rd_addr     = head_r;
  assign marker          = marker_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_popped_bit  = out_popped_r;
  assign out_marker_now  = out_marker_r;
  assign out_tape_length = out_len_r;

endmodule

`default_nettype wire

@@ src/cyclic_tag_machine_step.sv @@
// A load or a halting step passes the finish state on its way to the output register; a
// step passes the read state first, and the append state for each appended bit (0 to 31).
// Items are taken one at a time; the single write port of the tape memory, one appended
// bit per cycle, sets the step time.
// Reset (rst_n low at a clock edge) empties the tape, zeroes the marker and
// sets the production count to one and every production to empty.
`default_nettype none

module cyclic_tag_machine_step #(
  parameter int unsigned TAPE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic        in_tape_bit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_popped_bit,
  output logic [1:0]       out_marker_now,
  output logic [8:0]       out_tape_length,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int unsigned PTR_W = $clog2(TAPE_DEPTH);

  ctm_pkg::ctm_prod_t prod;
  logic [1:0]         marker;
  logic               mem_wr_en;
  logic [PTR_W-1:0]   mem_wr_addr;
  logic               mem_wr_data;
  logic [PTR_W-1:0]   mem_rd_addr;
  logic               mem_rd_data;

  // Configuration registers.
  ctm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .marker    (marker),
    .prod      (prod)
  );

  // Tape memory, one bit per entry.
  ctm_ram #(
    .WIDTH (1),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Sequencer.
  ctm_seq #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_tape_bit     (in_tape_bit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_popped_bit  (out_popped_bit),
    .out_marker_now  (out_marker_now),
    .out_tape_length (out_tape_length),
    .prod            (prod),
    .marker          (marker),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data)
  );

endmodule

`default_nettype wire

@@ src/ctm_chk.sv @@
// Port checker for the cyclic tag machine, bound to the top level.
// Depends on ctm_pkg.
`default_nettype none

module ctm_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status,
  input wire logic       out_popped_bit,
  input wire logic [1:0] out_marker_now,
  input wire logic [8:0] out_tape_length
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_popped_bit) && $stable(out_marker_now) && $stable(out_tape_length))
    else $error("result item changed while stalled");

  // Items are handled one at a time: after an accept the input is stalled.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ctm_pkg::ST_OK || out_status == ctm_pkg::ST_EMPTY ||
                   out_status == ctm_pkg::ST_FULL))
    else $error("undefined status code");

  // A halt pops nothing and leaves an empty tape.
  a_halt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ctm_pkg::ST_EMPTY |-> !out_popped_bit &&
      out_tape_length == 9'd0)
    else $error("halt reported with a nonempty tape");

endmodule

bind cyclic_tag_machine_step ctm_chk u_ctm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_popped_bit  (out_popped_bit),
  .out_marker_now  (out_marker_now),
  .out_tape_length (out_tape_length)
);

`default_nettype wire

@@ test/tb_cyclic_tag_machine_step.sv @@
// Self-checking testbench for cyclic_tag_machine_step: a directed script followed
// by random phases, each result compared with a tape-and-marker predictor.
// Depends on ctm_pkg and the cyclic_tag_machine_step RTL.
module tb_cyclic_tag_machine_step;

  localparam int TAPE_BITS    = 256;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SETTLE_GAP   = 8;
  localparam int TAIL_GAP     = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 250;

  // One result item as the block reports it.
  typedef struct packed {
    ctm_pkg::ctm_status_t status;
    logic                 popped;
    logic [1:0]           marker;
    logic [8:0]           length;
  } tag_result_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_STEP,
    ROW_WRITE
  } row_kind_t;

  // One line of the directed script: an item, or a register write.
  typedef struct packed {
    row_kind_t   kind;
    logic        bt;
    logic [2:0]  idx;
    logic [31:0] data;
    logic        known;
    tag_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic        in_tape_bit;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_popped_bit;
  logic [1:0]  out_marker_now;
  logic [8:0]  out_tape_length;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Predictor state: the tape as a bit queue, the marker and the registers.
  logic        model_tape[$];
  logic [1:0]  model_marker;
  logic [2:0]  model_count;
  logic [31:0] model_prod[4];

  tag_result_t expected_results[$];
  script_row_t script[$];
  int          mismatches;
  bit          quiet_phase;

  cyclic_tag_machine_step #(
    .TAPE_DEPTH(TAPE_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_tape_bit    (in_tape_bit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_popped_bit (out_popped_bit),
    .out_marker_now (out_marker_now),
    .out_tape_length(out_tape_length),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Expected result of one item; advances the predictor state.
  function automatic tag_result_t predict_tag_step(input ctm_pkg::ctm_op_t op,
                                                   input logic bt);
    tag_result_t r;
    logic [31:0] prod;
    int          len;
    int          cnt;
    int          i;
    r.status = ctm_pkg::ST_OK;
    r.popped = 1'b0;
    if (op == ctm_pkg::OP_LOAD) begin
      if (model_tape.size() >= TAPE_BITS) begin
        r.status = ctm_pkg::ST_FULL;
      end else begin
        model_tape.push_back(bt);
      end
    end else if (model_tape.size() == 0) begin
      r.status = ctm_pkg::ST_EMPTY;
    end else begin
      r.popped = model_tape.pop_front();
      if (r.popped) begin
        // Length is the position of the topmost one; zero if there is none.
        prod = model_prod[model_marker];
        len = 0;
        for (i = 31; i > 0 && len == 0; i--) begin
          if (prod[i]) begin
            len = i;
          end
        end
        if (model_tape.size() + len > TAPE_BITS) begin
          r.status = ctm_pkg::ST_FULL;
        end else begin
          for (i = 0; i < len; i++) begin
            model_tape.push_back(prod[i]);
          end
        end
      end
      // The marker moves only on a completed step.
      if (r.status == ctm_pkg::ST_OK) begin
        cnt = (model_count == 3'd0) ? 1 : (model_count > 3'd4) ? 4 : int'(model_count);
        model_marker = 2'((int'(model_marker) + 1) % cnt);
      end
    end
    r.marker = model_marker;
    r.length = 9'(model_tape.size());
    return r;
  endfunction

  // Random production: a sentinel one above up to max_len random bits,
  // with the occasional zero, empty or all-ones register.
  function automatic logic [31:0] random_production(input int max_len);
    int          len;
    logic [31:0] mask;
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      default: begin
        len  = $urandom_range(0, max_len);
        mask = (32'h1 << len) - 32'h1;
        return ($urandom & mask) | (32'h1 << len);
      end
    endcase
  endfunction

  function automatic script_row_t row_op(input row_kind_t kind, input logic bt);
    script_row_t r;
    r      = '0;
    r.kind = kind;
    r.bt   = bt;
    return r;
  endfunction

  function automatic script_row_t row_known(input row_kind_t kind, input logic bt,
                                            input ctm_pkg::ctm_status_t st,
                                            input logic pop,
                                            input logic [1:0] mk, input logic [8:0] len);
    script_row_t r;
    r             = row_op(kind, bt);
    r.known       = 1'b1;
    r.want.status = st;
    r.want.popped = pop;
    r.want.marker = mk;
    r.want.length = len;
    return r;
  endfunction

  function automatic script_row_t row_reg(input logic [2:0] idx, input logic [31:0] data);
    script_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // Offer one item after a random gap; the predictor runs once it is taken.
  task automatic send_item(input ctm_pkg::ctm_op_t op, input logic bt, input logic known,
                           input tag_result_t want);
    int          gap;
    tag_result_t r;
    gap = quiet_phase ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_tape_bit  <= bt;
    do @(posedge clk); while (in_stall);
    r = predict_tag_step(op, bt);
    expected_results.push_back(known ? want : r);
  endtask

  // Stop offering and wait until every result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == ctm_pkg::REG_COUNT) begin
      model_count = data[2:0];
    end else begin
      model_prod[idx - ctm_pkg::REG_PROD0] = data;
    end
  endtask

  // Result side: random stalls, one long hold-off, and the field checks.
  initial begin
    int          gap;
    int          taken;
    bit          held;
    tag_result_t want;
    taken = 0;
    held  = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = quiet_phase ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AT && !held) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected (status %0d)",
                                  out_status));
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_popped_bit !== want.popped)
          report_mismatch($sformatf("popped_bit got %0d want %0d",
                                    out_popped_bit, want.popped));
        if (out_marker_now !== want.marker)
          report_mismatch($sformatf("marker_now got %0d want %0d",
                                    out_marker_now, want.marker));
        if (out_tape_length !== want.length)
          report_mismatch($sformatf("tape_length got %0d want %0d",
                                    out_tape_length, want.length));
      end
    end
  end

  // Stimulus: reset, directed script, random phases, drain and verdict.
  initial begin
    int               k;
    int               j;
    int               span;
    int               runs;
    int               lead;
    int               sent_items;
    ctm_pkg::ctm_op_t op;
    mismatches   = 0;
    quiet_phase  = 1'b0;
    model_marker = 2'd0;
    model_count  = 3'd1;
    for (k = 0; k < 4; k++) begin
      model_prod[k] = 32'h1;
    end
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= ctm_pkg::OP_LOAD;
    in_tape_bit  <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= ctm_pkg::REG_COUNT;
    cfg_wdata    <= 32'h0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty tape halts, loads and steps with the reset registers.
    script.push_back(row_known(ROW_STEP, 1'b1, ctm_pkg::ST_EMPTY, 1'b0, 2'd0, 9'd0));
    script.push_back(row_known(ROW_LOAD, 1'b0, ctm_pkg::ST_OK, 1'b0, 2'd0, 9'd1));
    script.push_back(row_known(ROW_STEP, 1'b0, ctm_pkg::ST_OK, 1'b0, 2'd0, 9'd0));
    script.push_back(row_known(ROW_LOAD, 1'b1, ctm_pkg::ST_OK, 1'b0, 2'd0, 9'd1));
    // Longest production of all ones grows the tape toward full.
    script.push_back(row_reg(ctm_pkg::REG_PROD0, 32'hFFFF_FFFF));
    for (k = 0; k < 8; k++) begin
      script.push_back(row_op(ROW_STEP, k[0]));
    end
    // Sixteen ones land the tape exactly at full, then both kinds of overflow.
    script.push_back(row_reg(ctm_pkg::REG_PROD0, 32'h0001_FFFF));
    script.push_back(row_op(ROW_STEP, 1'b0));
    script.push_back(row_known(ROW_LOAD, 1'b1, ctm_pkg::ST_FULL, 1'b0, 2'd0, 9'd256));
    script.push_back(row_known(ROW_STEP, 1'b1, ctm_pkg::ST_FULL, 1'b1, 2'd0, 9'd255));
    // Empty, all-zero and zero-valued productions over four markers.
    script.push_back(row_reg(ctm_pkg::REG_COUNT, 32'd4));
    script.push_back(row_reg(ctm_pkg::REG_PROD0, 32'h0000_0001));
    script.push_back(row_reg(ctm_pkg::REG_PROD1, 32'h8000_0000));
    script.push_back(row_reg(ctm_pkg::REG_PROD2, 32'h0000_0001));
    script.push_back(row_reg(ctm_pkg::REG_PROD3, 32'h0000_0000));
    script.push_back(row_op(ROW_STEP, 1'b0));
    script.push_back(row_op(ROW_STEP, 1'b1));
    script.push_back(row_reg(ctm_pkg::REG_PROD1, 32'h0000_0001));
    script.push_back(row_op(ROW_STEP, 1'b0));
    script.push_back(row_op(ROW_STEP, 1'b0));
    // Count lowered below the marker, then counts above four and of zero.
    script.push_back(row_reg(ctm_pkg::REG_COUNT, 32'd2));
    script.push_back(row_op(ROW_STEP, 1'b1));
    script.push_back(row_reg(ctm_pkg::REG_COUNT, 32'd7));
    script.push_back(row_op(ROW_STEP, 1'b0));
    script.push_back(row_op(ROW_STEP, 1'b1));
    script.push_back(row_reg(ctm_pkg::REG_COUNT, 32'd0));
    script.push_back(row_op(ROW_STEP, 1'b0));
    script.push_back(row_op(ROW_LOAD, 1'b0));

    foreach (script[k]) begin
      if (script[k].kind == ROW_WRITE) begin
        settle();
        write_reg(script[k].idx, script[k].data);
      end else begin
        send_item((script[k].kind == ROW_STEP) ? ctm_pkg::OP_STEP : ctm_pkg::OP_LOAD,
                  script[k].bt, script[k].known, script[k].want);
      end
    end

    // Random phases: new registers, a run of loads, then mostly steps.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      settle();
      quiet_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: span = 2;
        1: span = 4;
        default: span = 31;
      endcase
      write_reg(ctm_pkg::REG_COUNT, 32'($urandom_range(0, 7)));
      write_reg(ctm_pkg::REG_PROD0, random_production(span));
      write_reg(ctm_pkg::REG_PROD1, random_production(span));
      write_reg(ctm_pkg::REG_PROD2, random_production(span));
      write_reg(ctm_pkg::REG_PROD3, random_production(span));
      runs = $urandom_range(60, 140);
      lead = $urandom_range(1, 24);
      for (j = 0; j < runs; j++) begin
        op = (j < lead || $urandom_range(0, 4) == 0) ? ctm_pkg::OP_LOAD : ctm_pkg::OP_STEP;
        send_item(op, 1'($urandom_range(0, 1)), 1'b0, '0);
        sent_items++;
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_GAP) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("cyclic_tag_machine_step: match");
    end else begin
      $display("cyclic_tag_machine_step: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("cyclic_tag_machine_step: mismatch");
    $finish;
  end

endmodule
